/* rtl/core/lpwc_pkg.sv */
// ----------------------------------------------------------------------------
// lpwc_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles between the long-press wipe controller's sequencer and datapath.
// ----------------------------------------------------------------------------
package lpwc_pkg;

  localparam int TIME_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CMP_W    = (TIME_W > CFG_W) ? TIME_W : CFG_W;
  localparam int DIV_CNT_W = $clog2(CMP_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RST       = 16'd5000;
  localparam logic [CFG_W-1:0] BLINK_HALF_RST = 16'd250;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_step;
    logic finish;
  } lpwc_cmd_t;

  typedef struct packed {
    logic need_blink;
    logic div_last;
    logic out_busy;
  } lpwc_sts_t;

endpackage

/* rtl/core/lpwc_div.sv */
// ----------------------------------------------------------------------------
// lpwc_div
// Restoring serial divider, one quotient bit per step; keeps only the last
// quotient bit (the blink phase).
// ----------------------------------------------------------------------------
module lpwc_div
  import lpwc_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [CMP_W-1:0] dividend,
  input  logic [CMP_W-1:0] divisor,
  output logic             q_bit,
  output logic             last
);

  logic [CMP_W-1:0]     rem_r, rem_nxt;
  logic [CMP_W-1:0]     dvd_r, dvd_nxt;
  logic [CMP_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 q_r, q_nxt;
  logic [CMP_W:0]       rem_sh;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[CMP_W-1]};
    dvd_nxt = {dvd_r[CMP_W-2:0], 1'b0};
    cnt_nxt = cnt_r + DIV_CNT_W'(1);
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = CMP_W'(rem_sh - {1'b0, dvs_r});
      q_nxt   = 1'b1;
    end else begin
      rem_nxt = rem_sh[CMP_W-1:0];
      q_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= '0;
      q_r   <= 1'b0;
    end else if (step) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      cnt_r <= cnt_nxt;
      q_r   <= q_nxt;
    end
  end

  assign q_bit = q_r;
  assign last  = (cnt_r == DIV_CNT_W'(CMP_W - 1));

endmodule

/* rtl/core/lpwc_datapath.sv */
// ----------------------------------------------------------------------------
// lpwc_datapath
// Config registers, input capture, per-tick state update, blink divider and
// output register.
// ----------------------------------------------------------------------------
module lpwc_datapath
  import lpwc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpwc_cmd_t            cmd,
  output lpwc_sts_t            sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_switch_level,
  input  logic                 in_cards_detect,
  input  logic                 in_card_init_ok,
  input  logic                 in_volume_init_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_led_ready,
  output logic                 out_led_error,
  output logic                 out_unit_is_active,
  output logic                 out_attention,
  output logic                 out_card_power,
  output logic                 out_clear_keys,
  output logic                 out_card_init_request,
  output logic                 out_wipe_request,
  output logic                 out_button_pressed
);

  logic [CFG_W-1:0] debounce_ms_r, hold_ms_r, blink_half_r;

  logic sw_r, cards_r, init_ok_r, vol_ok_r;

  logic [TIME_W-1:0] time_r, db_begin_r, hold_begin_r;
  logic              db_busy_r, debounced_r, seen_pressed_r, ignore_hold_r;
  logic              cards_seen_r, active_r, powered_r;
  logic [1:0]        lamp_r;
  logic              att_r, ck_r, ir_r, wr_r, blink_r;

  logic [TIME_W-1:0] db_begin_nxt, hold_begin_nxt, db_el, hold_el;
  logic              db_busy_nxt, debounced_nxt, seen_pressed_nxt, ignore_hold_nxt;
  logic              cards_seen_nxt, active_nxt, powered_nxt;
  logic [1:0]        lamp_nxt, lamp_fin;
  logic              att_nxt, ck_nxt, ir_nxt, wr_nxt, blink_nxt, btn;
  logic [CMP_W-1:0]  div_dvs;
  logic              q_bit, div_last;

  logic out_valid_r;
  logic led_ready_r, led_error_r, active_o_r, att_o_r, power_o_r;
  logic ck_o_r, ir_o_r, wr_o_r, btn_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_RST;
      hold_ms_r     <= HOLD_RST;
      blink_half_r  <= BLINK_HALF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ms_r <= cfg_data;
        REG_HOLD:       hold_ms_r     <= cfg_data;
        REG_BLINK_HALF: blink_half_r  <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sw_r      <= in_switch_level;
      cards_r   <= in_cards_detect;
      init_ok_r <= in_card_init_ok;
      vol_ok_r  <= in_volume_init_ok;
    end
  end

  always_comb begin
    db_begin_nxt     = db_begin_r;
    hold_begin_nxt   = hold_begin_r;
    db_busy_nxt      = db_busy_r;
    debounced_nxt    = debounced_r;
    seen_pressed_nxt = seen_pressed_r;
    ignore_hold_nxt  = ignore_hold_r;
    cards_seen_nxt   = cards_seen_r;
    active_nxt       = active_r;
    powered_nxt      = powered_r;
    lamp_nxt         = lamp_r;
    att_nxt          = 1'b0;
    ck_nxt           = 1'b0;
    ir_nxt           = 1'b0;
    wr_nxt           = 1'b0;
    blink_nxt        = 1'b0;
    btn              = debounced_r;
    db_el            = time_r - db_begin_r;
    hold_el          = '0;

    if (cards_r != cards_seen_r) begin
      cards_seen_nxt = cards_r;
      att_nxt        = 1'b1;
      if (cards_r) begin
        ignore_hold_nxt  = 1'b0;
        seen_pressed_nxt = 1'b0;
        ir_nxt           = 1'b1;
        if (!init_ok_r) begin
          lamp_nxt[1] = 1'b1;
          powered_nxt = 1'b0;
          ck_nxt      = 1'b1;
          active_nxt  = 1'b0;
        end else begin
          lamp_nxt[0] = 1'b1;
          powered_nxt = 1'b1;
          active_nxt  = 1'b1;
        end
      end else begin
        powered_nxt = 1'b0;
        ck_nxt      = 1'b1;
        active_nxt  = 1'b0;
        lamp_nxt    = 2'b00;
      end
    end

    if (cards_seen_nxt) begin
      if (!(db_busy_r && (CMP_W'(db_el) < CMP_W'(debounce_ms_r)))) begin
        db_busy_nxt = 1'b0;
        if (!sw_r != debounced_r) begin
          debounced_nxt = !sw_r;
          db_busy_nxt   = 1'b1;
          db_begin_nxt  = time_r;
        end
      end
      btn = debounced_nxt;
      if (btn != seen_pressed_nxt) begin
        seen_pressed_nxt = btn;
        if (btn) begin
          hold_begin_nxt = time_r;
          lamp_nxt[0]    = 1'b0;
          active_nxt     = 1'b0;
          att_nxt        = 1'b1;
        end else begin
          if (!ignore_hold_nxt) begin
            active_nxt = 1'b1;
            att_nxt    = 1'b1;
            lamp_nxt   = 2'b01;
          end
          ignore_hold_nxt = 1'b0;
        end
      end
      if (seen_pressed_nxt && !ignore_hold_nxt) begin
        hold_el = time_r - hold_begin_nxt;
        if (CMP_W'(hold_el) >= CMP_W'(hold_ms_r)) begin
          if (!powered_nxt) ir_nxt = 1'b1;
          wr_nxt = 1'b1;
          if (vol_ok_r) begin
            lamp_nxt    = 2'b01;
            active_nxt  = 1'b1;
            att_nxt     = 1'b1;
            powered_nxt = 1'b1;
          end else begin
            powered_nxt = 1'b0;
            ck_nxt      = 1'b1;
            lamp_nxt    = 2'b10;
            active_nxt  = 1'b0;
          end
          ignore_hold_nxt = 1'b1;
        end else begin
          blink_nxt = 1'b1;
        end
      end
    end

    div_dvs = (blink_half_r == '0) ? CMP_W'(1) : CMP_W'(blink_half_r);
  end

  lpwc_div u_div (
    .clk      (clk),
    .load     (cmd.eval),
    .step     (cmd.div_step),
    .dividend (CMP_W'(hold_el)),
    .divisor  (div_dvs),
    .q_bit    (q_bit),
    .last     (div_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r         <= '0;
      db_busy_r      <= 1'b1;
      db_begin_r     <= '0;
      debounced_r    <= 1'b0;
      seen_pressed_r <= 1'b0;
      ignore_hold_r  <= 1'b0;
      hold_begin_r   <= '0;
      cards_seen_r   <= 1'b0;
      lamp_r         <= 2'b00;
      active_r       <= 1'b0;
      powered_r      <= 1'b0;
    end else if (cmd.eval) begin
      time_r         <= time_r + TIME_W'(1);
      db_busy_r      <= db_busy_nxt;
      db_begin_r     <= db_begin_nxt;
      debounced_r    <= debounced_nxt;
      seen_pressed_r <= seen_pressed_nxt;
      ignore_hold_r  <= ignore_hold_nxt;
      hold_begin_r   <= hold_begin_nxt;
      cards_seen_r   <= cards_seen_nxt;
      lamp_r         <= lamp_nxt;
      active_r       <= active_nxt;
      powered_r      <= powered_nxt;
    end else if (cmd.finish) begin
      lamp_r <= lamp_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      att_r   <= att_nxt;
      ck_r    <= ck_nxt;
      ir_r    <= ir_nxt;
      wr_r    <= wr_nxt;
      blink_r <= blink_nxt;
    end
  end

  assign lamp_fin = blink_r ? {q_bit, lamp_r[0]} : lamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      led_ready_r <= lamp_fin[0];
      led_error_r <= lamp_fin[1];
      active_o_r  <= active_r;
      att_o_r     <= att_r;
      power_o_r   <= powered_r;
      ck_o_r      <= ck_r;
      ir_o_r      <= ir_r;
      wr_o_r      <= wr_r;
      btn_o_r     <= debounced_r;
    end
  end

  assign sts.need_blink = blink_nxt;
  assign sts.div_last   = div_last;
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid             = out_valid_r;
  assign out_led_ready         = led_ready_r;
  assign out_led_error         = led_error_r;
  assign out_unit_is_active    = active_o_r;
  assign out_attention         = att_o_r;
  assign out_card_power        = power_o_r;
  assign out_clear_keys        = ck_o_r;
  assign out_card_init_request = ir_o_r;
  assign out_wipe_request      = wr_o_r;
  assign out_button_pressed    = btn_o_r;

endmodule

/* rtl/core/lpwc_ctrl.sv */
// ----------------------------------------------------------------------------
// lpwc_ctrl
// Sequencer: accept a tick, evaluate, run the blink divider if needed, then
// hand the result to the output register.
// ----------------------------------------------------------------------------
module lpwc_ctrl
  import lpwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lpwc_sts_t sts,
  output lpwc_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   stall_r, stall_nxt;

  always_comb begin
    state_nxt = state_r;
    stall_nxt = stall_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !stall_r) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EVAL;
          stall_nxt   = 1'b1;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_blink ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
          stall_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        stall_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stall_r <= stall_nxt;
    end
  end

  assign in_stall = stall_r;

endmodule

/* rtl/core/long_press_wipe_controller_unit.sv */
// ----------------------------------------------------------------------------
// long_press_wipe_controller_unit
// Flow: an accepted tick is captured, evaluated and, while the hold blink runs,
// run through the 16-step serial divider (blink phase), then out_valid rises.
// Input: a new tick is taken only once the previous result reaches the output register.
// Reset: synchronous rst_n restores register defaults and starts time at 0.
// ----------------------------------------------------------------------------
module long_press_wipe_controller_unit
  import lpwc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_switch_level,
  input  logic                 in_cards_detect,
  input  logic                 in_card_init_ok,
  input  logic                 in_volume_init_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_led_ready,
  output logic                 out_led_error,
  output logic                 out_unit_is_active,
  output logic                 out_attention,
  output logic                 out_card_power,
  output logic                 out_clear_keys,
  output logic                 out_card_init_request,
  output logic                 out_wipe_request,
  output logic                 out_button_pressed
);

  lpwc_cmd_t cmd;
  lpwc_sts_t sts;

  assign cfg_ready = 1'b1;

  lpwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpwc_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_switch_level       (in_switch_level),
    .in_cards_detect       (in_cards_detect),
    .in_card_init_ok       (in_card_init_ok),
    .in_volume_init_ok     (in_volume_init_ok),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_led_ready         (out_led_ready),
    .out_led_error         (out_led_error),
    .out_unit_is_active    (out_unit_is_active),
    .out_attention         (out_attention),
    .out_card_power        (out_card_power),
    .out_clear_keys        (out_clear_keys),
    .out_card_init_request (out_card_init_request),
    .out_wipe_request      (out_wipe_request),
    .out_button_pressed    (out_button_pressed)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for long_press_wipe_controller_unit. A short directed
// table, then random press, hold, bounce and card sessions are driven as 1 ms
// ticks under several timer settings. Every result is compared field by field
// against the directed table's value or an in-bench model of the controller.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lpwc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic sw;
    logic cards;
    logic init_ok;
    logic vol_ok;
  } tick_in_t;

  typedef struct packed {
    logic led_ready;
    logic led_error;
    logic unit_is_active;
    logic attention;
    logic card_power;
    logic clear_keys;
    logic card_init_request;
    logic wipe_request;
    logic button_pressed;
  } tick_out_t;

  typedef struct packed {
    tick_in_t  stim;
    logic      checked;
    tick_out_t want;
  } dir_row_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic in_switch_level, in_cards_detect, in_card_init_ok, in_volume_init_ok;
  logic out_valid, out_stall;
  logic out_led_ready, out_led_error, out_unit_is_active, out_attention;
  logic out_card_power, out_clear_keys, out_card_init_request, out_wipe_request;
  logic out_button_pressed;

  long_press_wipe_controller_unit dut (.*);

  // controller model state
  logic [TIME_W-1:0] time_now, db_since, press_since;
  logic db_open, db_level, btn_held, hold_done, cards_in, mounted, powered_up;
  logic [1:0] lamps;  // bit0 ready, bit1 error
  logic [CFG_W-1:0] db_ms, hold_len_ms, blink_ms;

  tick_out_t tick_results_q[$];
  dir_row_t  dir_rows[$];

  int errors, ticks_sent, results_seen, insertions, wipes, settings;
  int idle_cycles;
  bit quiet, hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_model();
    time_now = '0; db_since = '0; press_since = '0;
    db_open = 1'b1; db_level = 1'b0; btn_held = 1'b0; hold_done = 1'b0;
    cards_in = 1'b0; mounted = 1'b0; powered_up = 1'b0; lamps = 2'b00;
    db_ms = DEBOUNCE_RST; hold_len_ms = HOLD_RST; blink_ms = BLINK_HALF_RST;
  endtask

  task automatic predict_tick(input tick_in_t t, output tick_out_t r);
    logic [TIME_W-1:0] since_change, held_for, half, phase;
    r = '0;
    if (t.cards != cards_in) begin
      cards_in = t.cards;
      r.attention = 1'b1;
      if (t.cards) begin
        insertions++;
        hold_done = 1'b0;
        btn_held = 1'b0;
        r.card_init_request = 1'b1;
        if (!t.init_ok) begin
          lamps[1] = 1'b1;
          powered_up = 1'b0;
          r.clear_keys = 1'b1;
          mounted = 1'b0;
        end else begin
          lamps[0] = 1'b1;
          powered_up = 1'b1;
          mounted = 1'b1;
        end
      end else begin
        powered_up = 1'b0;
        r.clear_keys = 1'b1;
        mounted = 1'b0;
        lamps = 2'b00;
      end
    end
    if (cards_in) begin
      since_change = time_now - db_since;
      if (!(db_open && since_change < db_ms)) begin
        db_open = 1'b0;
        if (!t.sw != db_level) begin
          db_level = !t.sw;
          db_open = 1'b1;
          db_since = time_now;
        end
      end
      if (db_level != btn_held) begin
        btn_held = db_level;
        if (db_level) begin
          press_since = time_now;
          lamps[0] = 1'b0;
          mounted = 1'b0;
          r.attention = 1'b1;
        end else begin
          if (!hold_done) begin
            mounted = 1'b1;
            r.attention = 1'b1;
            lamps = 2'b01;
          end
          hold_done = 1'b0;
        end
      end
      if (btn_held && !hold_done) begin
        held_for = time_now - press_since;
        if (held_for >= hold_len_ms) begin
          wipes++;
          if (!powered_up) r.card_init_request = 1'b1;
          r.wipe_request = 1'b1;
          if (t.vol_ok) begin
            lamps = 2'b01;
            mounted = 1'b1;
            r.attention = 1'b1;
            powered_up = 1'b1;
          end else begin
            powered_up = 1'b0;
            r.clear_keys = 1'b1;
            lamps = 2'b10;
            mounted = 1'b0;
          end
          hold_done = 1'b1;
        end else begin
          half = (blink_ms == '0) ? 16'd1 : blink_ms;
          phase = held_for / half;
          lamps[1] = phase[0];
        end
      end
    end
    r.led_ready = lamps[0];
    r.led_error = lamps[1];
    r.unit_is_active = mounted;
    r.card_power = powered_up;
    r.button_pressed = db_level;
    time_now = time_now + TIME_W'(1);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic tick_in_t rand_tick(input logic sw, input logic cards);
    tick_in_t t;
    t.sw = sw;
    t.cards = cards;
    t.init_ok = ($urandom_range(0, 9) < 8);
    t.vol_ok = ($urandom_range(0, 9) < 7);
    return t;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) flag_mismatch($sformatf("%s got %b want %b", name, got, want));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE:   db_ms = val;
      REG_HOLD:       hold_len_ms = val;
      REG_BLINK_HALF: blink_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timers(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] b);
    write_reg(REG_DEBOUNCE, d);
    write_reg(REG_HOLD, h);
    write_reg(REG_BLINK_HALF, b);
    settings++;
  endtask

  task automatic send_tick(input tick_in_t t, input logic use_want, input tick_out_t want);
    int gap;
    tick_out_t predicted;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_switch_level <= t.sw;
    in_cards_detect <= t.cards;
    in_card_init_ok <= t.init_ok;
    in_volume_init_ok <= t.vol_ok;
    do @(posedge clk); while (in_stall);
    predict_tick(t, predicted);
    tick_results_q.push_back(use_want ? want : predicted);
    ticks_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input tick_in_t s, input logic c, input tick_out_t w);
    dir_row_t row;
    row.stim = s;
    row.checked = c;
    row.want = w;
    dir_rows.push_back(row);
  endtask

  // one press: bounce, hold, bounce, release
  task automatic run_press();
    int n, lim;
    n = $urandom_range(0, 3);
    repeat (n) send_tick(rand_tick(1'($urandom_range(0, 1)), 1'b1), 1'b0, '0);
    lim = int'(hold_len_ms) + int'(db_ms) + 3;
    if (lim > 60) lim = 60;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(0, lim);
    repeat (n) send_tick(rand_tick(1'b0, 1'b1), 1'b0, '0);
    n = $urandom_range(0, 3);
    repeat (n) send_tick(rand_tick(1'($urandom_range(0, 1)), 1'b1), 1'b0, '0);
    lim = (db_ms > 10) ? 10 : int'(db_ms);
    n = $urandom_range(1, 4) + lim;
    repeat (n) send_tick(rand_tick(1'b1, 1'b1), 1'b0, '0);
  endtask

  task automatic run_phase(input int n);
    int stop_at, pick, k;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_press();
      end else if (pick < 80) begin
        k = $urandom_range(1, 4);
        repeat (k) send_tick(rand_tick(1'($urandom_range(0, 1)), 1'b0), 1'b0, '0);
      end else begin
        k = $urandom_range(1, 6);
        repeat (k)
          send_tick(rand_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                    1'b0, '0);
      end
    end
  endtask

  // result side
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : monitor
    tick_out_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_led_ready, out_led_error, out_unit_is_active, out_attention,
             out_card_power, out_clear_keys, out_card_init_request, out_wipe_request,
             out_button_pressed};
      results_seen++;
      if (tick_results_q.size() == 0) begin
        flag_mismatch("result with no pending expectation");
      end else begin
        want = tick_results_q.pop_front();
        check_field("led_ready", got.led_ready, want.led_ready);
        check_field("led_error", got.led_error, want.led_error);
        check_field("unit_is_active", got.unit_is_active, want.unit_is_active);
        check_field("attention", got.attention, want.attention);
        check_field("card_power", got.card_power, want.card_power);
        check_field("clear_keys", got.clear_keys, want.clear_keys);
        check_field("card_init_request", got.card_init_request, want.card_init_request);
        check_field("wipe_request", got.wipe_request, want.wipe_request);
        check_field("button_pressed", got.button_pressed, want.button_pressed);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_switch_level = 1'b1;
    in_cards_detect = 1'b0;
    in_card_init_ok = 1'b0;
    in_volume_init_ok = 1'b0;
    errors = 0; ticks_sent = 0; results_seen = 0;
    insertions = 0; wipes = 0; settings = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    reset_model();

    // stim: sw cards init_ok vol_ok
    // want: ready error active attn power clear init wipe pressed
    add_row(4'b1000, 1'b1, 9'b000000000);  // idle, no cards
    add_row(4'b1100, 1'b1, 9'b010101100);  // insertion, init fails
    add_row(4'b1011, 1'b1, 9'b000101000);  // removal
    add_row(4'b1110, 1'b1, 9'b101110100);  // insertion, init ok
    add_row(4'b0100, 1'b0, '0);            // press
    add_row(4'b1100, 1'b0, '0);            // bounce inside window
    add_row(4'b0100, 1'b0, '0);
    add_row(4'b0100, 1'b0, '0);
    add_row(4'b0101, 1'b0, '0);            // hold reached, wipe ok
    add_row(4'b0100, 1'b0, '0);
    add_row(4'b1100, 1'b0, '0);            // release after wipe, no remount
    add_row(4'b0100, 1'b0, '0);            // press frozen by debounce
    add_row(4'b0100, 1'b0, '0);
    add_row(4'b0100, 1'b0, '0);
    add_row(4'b0100, 1'b0, '0);
    add_row(4'b0100, 1'b0, '0);
    add_row(4'b0100, 1'b0, '0);            // wipe fails, power off
    add_row(4'b1111, 1'b0, '0);
    add_row(4'b0101, 1'b0, '0);
    add_row(4'b0101, 1'b0, '0);
    add_row(4'b0101, 1'b0, '0);
    add_row(4'b0101, 1'b0, '0);
    add_row(4'b0101, 1'b0, '0);            // last tick before the wipe while unpowered
    add_row(4'b0101, 1'b0, '0);
    add_row(4'b1111, 1'b0, '0);
    add_row(4'b0011, 1'b0, '0);            // removal while pressed

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_timers(16'd2, 16'd4, 16'd2);
    for (i = 0; i < dir_rows.size(); i++)
      send_tick(dir_rows[i].stim, dir_rows[i].checked, dir_rows[i].want);
    drain();

    // long receiver hold-off while items keep coming
    set_timers(16'd5, 16'd20, 16'd3);
    hold_off_req = 1'b1;
    run_phase(250);
    drain();

    set_timers(16'd0, 16'd0, 16'd0);
    run_phase(150);
    drain();

    // back to back, then sender waits for all results
    quiet = 1'b1;
    set_timers(16'd1, 16'd1, 16'd1);
    run_phase(75);
    drain();
    quiet = 1'b0;
    run_phase(75);
    drain();

    set_timers(16'd3, 16'd30, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hA5A5);
    run_phase(150);
    drain();

    set_timers(16'hFFFF, 16'd40, 16'd5);
    run_phase(80);
    drain();

    set_timers(16'd2, 16'hFFFF, 16'd7);
    run_phase(80);
    drain();

    set_timers(DEBOUNCE_RST, HOLD_RST, BLINK_HALF_RST);
    run_phase(80);
    drain();

    set_timers(16'd4, 16'd25, 16'd4);
    run_phase(40);
    drain();

    repeat (40) @(posedge clk);
    $display("summary: %0d ticks, %0d results, %0d mismatches, %0d timer settings",
             ticks_sent, results_seen, errors, settings);
    $display("summary: %0d card insertions, %0d wipe requests",
             insertions, wipes);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
